// ===== hdl/gdfs_pkg.sv =====
// Shared constants, codes and types of the depth-first graph walker.
// Used by the channel interfaces, the RAM wrapper users and the top level.
package gdfs_pkg;

    localparam int MAX_VERTICES   = 64;
    localparam int MAX_LIST_NODES = 256;
    localparam int STACK_DEPTH    = MAX_LIST_NODES + 1;
    localparam int RESULT_LIMIT   = 64;

    localparam int VTX_W   = 6;
    localparam int FUNC_W  = 2;
    localparam int VC_W    = 7;
    localparam int LINK_W  = $clog2(MAX_LIST_NODES + 1);
    localparam int NODE_AW = $clog2(MAX_LIST_NODES);
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int CNT_W   = $clog2(RESULT_LIMIT + 1);
    localparam int CFG_IDX_W = 1;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_LIST_NODES);
    localparam logic [VC_W-1:0]   VC_MAX    = VC_W'(MAX_VERTICES);
    localparam logic [VC_W-1:0]   VC_RESET  = VC_W'(64);

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WALK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDIR_OFF    = 1'b1;

    typedef struct packed {
        logic [LINK_W-1:0] link;
        logic [VTX_W-1:0]  target;
    } t_node;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic             last;
        logic             dropped;
    } t_result;

endpackage

// ===== hdl/gdfs_if.sv =====
// Valid/ready channel interfaces: command input, visit output, register writes.
// Depends on gdfs_pkg for field widths.
interface gdfs_in_if;
    logic                         valid;
    logic                         ready;
    logic [gdfs_pkg::FUNC_W-1:0]  func;
    logic [gdfs_pkg::VTX_W-1:0]   vertex_a;
    logic [gdfs_pkg::VTX_W-1:0]   vertex_b;
    modport source (output valid, func, vertex_a, vertex_b, input ready);
    modport sink   (input valid, func, vertex_a, vertex_b, output ready);
endinterface

interface gdfs_out_if;
    logic                        valid;
    logic                        ready;
    logic [gdfs_pkg::VTX_W-1:0]  visited_vertex;
    logic                        last_visit;
    logic                        edges_dropped;
    modport source (output valid, visited_vertex, last_visit, edges_dropped, input ready);
    modport sink   (input valid, visited_vertex, last_visit, edges_dropped, output ready);
endinterface

interface gdfs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gdfs_pkg::CFG_IDX_W-1:0]  index;
    logic [gdfs_pkg::VC_W-1:0]       data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/graph_dfs_stack_traversal.sv =====
// Graph builder with depth-first walk.
// Channels: i_in takes command beats (func, vertex_a, vertex_b); o_out gives one
// beat per visited vertex (visited_vertex, last_visit, edges_dropped); i_cfg
// writes vertex_count (index 0) and undirected_off (index 1), always ready.
// An add-edge beat goes from accept through a head RAM read, then a node RAM and
// head RAM write, and one more read and write pair for the reverse direction when
// the edge is stored both ways (S_EA, S_EAW, S_EB, S_EBW). A clear beat or a bad
// edge is done at accept. A walk pops (S_POP) and checks (S_CHK) each stack entry,
// reads a visited vertex's list head (S_HD), walks its adjacency nodes (S_LST,
// S_NW), reverses a pushed run by swaps (S_R0 to S_R3) and finishes in S_FIN; the
// one-read stack RAM and the node-list chase set these steps.
// A walk's results trail its visits by one vertex, since a vertex is held until
// the next visit or the end tells whether it is the last.
// i_in is ready only while no command is at work. When the receiver stalls, the
// output register holds its beat and the walk waits at its next visit.
// Reset (synchronous, i_rst_n low) empties all lists through per-vertex valid
// bits at once, restores vertex_count 64 and undirected_off 0; no clearing pass.
module graph_dfs_stack_traversal (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gdfs_in_if.sink     i_in,
    gdfs_out_if.source  o_out,
    gdfs_cfg_if.sink    i_cfg
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EA   = 4'd1;
    localparam logic [3:0] S_EAW  = 4'd2;
    localparam logic [3:0] S_EB   = 4'd3;
    localparam logic [3:0] S_EBW  = 4'd4;
    localparam logic [3:0] S_POP  = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_HD   = 4'd7;
    localparam logic [3:0] S_LST  = 4'd8;
    localparam logic [3:0] S_NW   = 4'd9;
    localparam logic [3:0] S_R0   = 4'd10;
    localparam logic [3:0] S_R1   = 4'd11;
    localparam logic [3:0] S_R2   = 4'd12;
    localparam logic [3:0] S_R3   = 4'd13;
    localparam logic [3:0] S_FIN  = 4'd14;

    localparam int VW = gdfs_pkg::VTX_W;
    localparam int LW = gdfs_pkg::LINK_W;
    localparam int SW = gdfs_pkg::STACK_AW;

    logic [3:0]                    r_state;
    logic [gdfs_pkg::VC_W-1:0]     r_vc;
    logic                          r_undir_off;
    logic [LW-1:0]                 r_used;
    logic                          r_drop;
    logic [gdfs_pkg::MAX_VERTICES-1:0] r_hvalid;
    logic [gdfs_pkg::MAX_VERTICES-1:0] r_visited;
    logic [VW-1:0]                 r_a;
    logic [VW-1:0]                 r_b;
    logic [SW-1:0]                 r_top;
    logic [SW-1:0]                 r_lo;
    logic [SW-1:0]                 r_hi;
    logic [VW-1:0]                 r_tmp;
    logic [LW-1:0]                 r_p;
    logic [gdfs_pkg::CNT_W-1:0]    r_count;
    logic                          r_hv_rd;
    logic                          r_pend_v;
    gdfs_pkg::t_result             r_pend;
    logic                          r_out_valid;
    gdfs_pkg::t_result             r_out;

    logic [gdfs_pkg::VC_W-1:0]     n_live;
    logic [VW-1:0]                 head_raddr;
    logic [LW-1:0]                 head_rdata;
    logic [LW-1:0]                 head_val;
    logic                          head_we;
    logic [VW-1:0]                 head_waddr;
    logic                          node_we;
    gdfs_pkg::t_node               node_wdata;
    gdfs_pkg::t_node               node_rdata;
    logic [SW-1:0]                 stk_raddr;
    logic [VW-1:0]                 stk_rdata;
    logic                          stk_we;
    logic [SW-1:0]                 stk_waddr;
    logic [VW-1:0]                 stk_wdata;
    logic                          in_acc;
    logic                          out_free;
    logic                          out_load;
    logic [LW:0]                   need_sum;
    logic                          v_skip;
    logic                          t_push;

    assign n_live   = (r_vc > gdfs_pkg::VC_MAX) ? gdfs_pkg::VC_MAX : r_vc;
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign head_val = r_hv_rd ? head_rdata : gdfs_pkg::NULL_LINK;
    assign need_sum = {1'b0, r_used} + (r_undir_off ? (LW+1)'(1) : (LW+1)'(2));
    assign v_skip   = ({1'b0, stk_rdata} >= n_live) || r_visited[stk_rdata];
    assign t_push   = ({1'b0, node_rdata.target} < n_live) && !r_visited[node_rdata.target]
                      && (r_top < SW'(gdfs_pkg::STACK_DEPTH));
    assign out_load = r_pend_v && out_free
                      && (((r_state == S_CHK) && !v_skip) || (r_state == S_FIN));

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid          = r_out_valid;
    assign o_out.visited_vertex = r_out.vertex;
    assign o_out.last_visit     = r_out.last;
    assign o_out.edges_dropped  = r_out.dropped;

    // RAM address and write selection
    always_comb begin
        head_raddr = r_a;
        head_we    = 1'b0;
        head_waddr = r_a;
        node_we    = 1'b0;
        node_wdata = '{link: head_val, target: r_b};
        stk_raddr  = r_top;
        stk_we     = 1'b0;
        stk_waddr  = r_top;
        stk_wdata  = node_rdata.target;
        unique case (r_state)
            S_IDLE: begin
                stk_waddr = '0;
                stk_wdata = i_in.vertex_a;
                stk_we    = in_acc && (i_in.func == gdfs_pkg::FUNC_WALK)
                            && ({1'b0, i_in.vertex_a} < n_live);
            end
            S_EAW: begin
                head_we = 1'b1;
                node_we = 1'b1;
            end
            S_EB: begin
                head_raddr = r_b;
            end
            S_EBW: begin
                head_we    = 1'b1;
                head_waddr = r_b;
                node_we    = 1'b1;
                node_wdata = '{link: head_val, target: r_a};
            end
            S_POP: begin
                stk_raddr = r_top - SW'(1);
            end
            S_CHK: begin
                head_raddr = stk_rdata;
            end
            S_NW: begin
                stk_we = t_push;
            end
            S_R0: begin
                stk_raddr = r_lo;
            end
            S_R1: begin
                stk_raddr = r_hi - SW'(1);
            end
            S_R2: begin
                stk_we    = 1'b1;
                stk_waddr = r_lo;
                stk_wdata = stk_rdata;
            end
            S_R3: begin
                stk_we    = 1'b1;
                stk_waddr = r_hi - SW'(1);
                stk_wdata = r_tmp;
            end
            default: begin
            end
        endcase
    end

    gdfs_ram #(.DEPTH(gdfs_pkg::MAX_VERTICES), .WIDTH(LW)) u_head (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (r_used),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata)
    );

    gdfs_ram #(.DEPTH(gdfs_pkg::MAX_LIST_NODES), .WIDTH($bits(gdfs_pkg::t_node))) u_node (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (r_used[gdfs_pkg::NODE_AW-1:0]),
        .i_wdata (node_wdata),
        .i_raddr (r_p[gdfs_pkg::NODE_AW-1:0]),
        .o_rdata (node_rdata)
    );

    gdfs_ram #(.DEPTH(gdfs_pkg::STACK_DEPTH), .WIDTH(VW)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_hv_rd <= r_hvalid[head_raddr];
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vc        <= gdfs_pkg::VC_RESET;
            r_undir_off <= 1'b0;
            r_used      <= '0;
            r_drop      <= 1'b0;
            r_hvalid    <= '0;
            r_visited   <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    gdfs_pkg::CFG_VERTEX_COUNT: r_vc        <= i_cfg.data;
                    gdfs_pkg::CFG_UNDIR_OFF:    r_undir_off <= i_cfg.data[0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (head_we) begin
                r_hvalid[head_waddr] <= 1'b1;
            end
            if (node_we) begin
                r_used <= r_used + LW'(1);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_a <= i_in.vertex_a;
                        r_b <= i_in.vertex_b;
                        unique case (i_in.func)
                            gdfs_pkg::FUNC_ADD: begin
                                if (({1'b0, i_in.vertex_a} >= n_live)
                                        || ({1'b0, i_in.vertex_b} >= n_live)
                                        || (need_sum > (LW+1)'(gdfs_pkg::MAX_LIST_NODES))) begin
                                    r_drop <= 1'b1;
                                end else begin
                                    r_state <= S_EA;
                                end
                            end
                            gdfs_pkg::FUNC_WALK: begin
                                if ({1'b0, i_in.vertex_a} < n_live) begin
                                    r_visited <= '0;
                                    r_top     <= SW'(1);
                                    r_count   <= '0;
                                    r_state   <= S_POP;
                                end
                            end
                            gdfs_pkg::FUNC_CLEAR: begin
                                r_hvalid <= '0;
                                r_used   <= '0;
                                r_drop   <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_EA:  r_state <= S_EAW;
                S_EAW: r_state <= r_undir_off ? S_IDLE : S_EB;
                S_EB:  r_state <= S_EBW;
                S_EBW: r_state <= S_IDLE;
                S_POP: begin
                    if ((r_top == '0) || (r_count == gdfs_pkg::CNT_W'(gdfs_pkg::RESULT_LIMIT))) begin
                        r_state <= S_FIN;
                    end else begin
                        r_top   <= r_top - SW'(1);
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (v_skip) begin
                        r_state <= S_POP;
                    end else if (!r_pend_v || out_free) begin
                        // release the previous visit, hold this one until we know whether it is last
                        if (r_pend_v) begin
                            r_out <= r_pend;
                        end
                        r_pend    <= '{vertex: stk_rdata, last: 1'b0, dropped: r_drop};
                        r_pend_v  <= 1'b1;
                        r_visited[stk_rdata] <= 1'b1;
                        r_count   <= r_count + gdfs_pkg::CNT_W'(1);
                        r_lo      <= r_top;
                        r_state   <= S_HD;
                    end
                end
                S_HD: begin
                    r_p     <= head_val;
                    r_state <= S_LST;
                end
                S_LST: begin
                    if (r_p < r_used) begin
                        r_state <= S_NW;
                    end else begin
                        r_hi    <= r_top;
                        r_state <= S_R0;
                    end
                end
                S_NW: begin
                    if (t_push) begin
                        r_top <= r_top + SW'(1);
                    end
                    r_p     <= node_rdata.link;
                    r_state <= S_LST;
                end
                S_R0: begin
                    // reverse the pushed run so the list head pops first
                    if ({1'b0, r_hi} > ({1'b0, r_lo} + (SW+1)'(1))) begin
                        r_state <= S_R1;
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_R1: begin
                    r_tmp   <= stk_rdata;
                    r_state <= S_R2;
                end
                S_R2: r_state <= S_R3;
                S_R3: begin
                    r_lo    <= r_lo + SW'(1);
                    r_hi    <= r_hi - SW'(1);
                    r_state <= S_R0;
                end
                S_FIN: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out       <= '{vertex: r_pend.vertex, last: 1'b1, dropped: r_pend.dropped};
                        r_pend_v    <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/gdfs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gdfs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
